// ===== design/assert_macros.svh =====
// Assertion macros for the block's RTL; included by the top-level file.
// Each use expects clk and arst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property that must hold on every clock edge out of reset.
`define FBA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Same-cycle implication.
`define FBA_ASSERT_IMPL(lbl, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) else $error(msg);
`endif

// ===== design/fba_pkg.sv =====
// Package for the first-fit block map allocator: codes, defaults and
// the divider result type. Used by every module of the block.
package fba_pkg;
	localparam int MAX_BLOCKS_DEF = 1024;

	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_FREE  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [1:0] ENT_FREE  = 2'd0;
	localparam logic [1:0] ENT_USED  = 2'd1;
	localparam logic [1:0] ENT_START = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_RUN    = 3'd1;
	localparam logic [2:0] ST_ZERO      = 3'd2;
	localparam logic [2:0] ST_BAD_ADDR  = 3'd3;
	localparam logic [2:0] ST_NOT_START = 3'd4;

	localparam logic [1:0] REG_BLOCK_SIZE  = 2'd0;
	localparam logic [1:0] REG_BLOCK_COUNT = 2'd1;
	localparam logic [1:0] REG_ARENA_BASE  = 2'd2;

	typedef struct packed {
		logic        done;
		logic [31:0] quot;
		logic [16:0] rem;
	} div_res_t;
endpackage

// ===== design/fba_div.sv =====
// Radix-2 restoring divider, 32-bit dividend by 17-bit divisor.
// Depends on fba_pkg for the result type.
module fba_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [31:0]         dividend,
	input  logic [16:0]         divisor,
	output fba_pkg::div_res_t   res
);
	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [31:0] quot_q;
	logic [17:0] rem_q;
	logic [16:0] dvs_q;
	logic [17:0] rem_sh;
	logic        ge;

	assign rem_sh = {rem_q[16:0], quot_q[31]};
	assign ge     = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[30:0], ge};
			rem_q  <= ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
		end
	end

	assign res.done = done_q;
	assign res.quot = quot_q;
	assign res.rem  = rem_q[16:0];
endmodule

// ===== design/fba_map.sv =====
// Block map storage: one write port, one read port, registered read data.
// Takes its default depth from fba_pkg; entry codes come from fba_pkg at the users.
module fba_map #(
	parameter int MAX_BLOCKS = fba_pkg::MAX_BLOCKS_DEF,
	localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [1:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [1:0]    rdata
);
	logic [1:0] mem [MAX_BLOCKS];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end
endmodule

// ===== design/first_fit_block_map_allocator.sv =====
// Top level of the first-fit block map allocator: command sequencer,
// config registers and output register. Uses fba_pkg, fba_div, fba_map.
//
//  channel | signals                                  | direction
//  cfg     | cfg_we, cfg_index, cfg_data              | in, write only
//  in      | in_valid, in_stall, cmd, request_size, address | in word
//  out     | out_valid, out_stall, status, block_address    | out word
//
// Allocate: divide, scan the map for a free run, mark the run, form the address.
// Free: divide, check and free the start entry, free the used entries after it; clear: wipe the map.
// Scans and walks go through the single map read port, one entry per cycle.
// After reset a clearing pass over all MAX_BLOCKS entries runs before the first word.
// One word at a time; a finished result waits in the output register while
// the next word is taken, and the sequencer holds while that register is full and stalled.
`include "assert_macros.svh"
module first_fit_block_map_allocator #(
	parameter int MAX_BLOCKS = fba_pkg::MAX_BLOCKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [31:0] request_size,
	input  logic [31:0] address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] block_address
);
	localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int LW = 17 + CW;
	localparam int PW = 17 + AW;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLR   = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_SCAN  = 4'd3;
	localparam logic [3:0] S_MARK  = 4'd4;
	localparam logic [3:0] S_ADDR  = 4'd5;
	localparam logic [3:0] S_FRD   = 4'd6;
	localparam logic [3:0] S_FCK   = 4'd7;
	localparam logic [3:0] S_FWALK = 4'd8;
	localparam logic [3:0] S_FIN   = 4'd9;

	logic [3:0]    state_q;
	logic [16:0]   bs_q;
	logic [10:0]   bc_q;
	logic [31:0]   base_q;
	logic [1:0]    cmd_q;
	logic          clr_res_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] run_q;
	logic [CW-1:0] need_q;
	logic [CW-1:0] left_q;
	logic [AW-1:0] start_q;
	logic [AW-1:0] wr_q;
	logic [PW-1:0] prod_q;
	logic          rv_s1;
	logic [CW-1:0] pos_s1;
	logic [2:0]    res_st_q;
	logic [31:0]   res_addr_q;
	logic          out_valid_q;
	logic [2:0]    status_q;
	logic [31:0]   addr_q;

	logic [16:0]   bs_eff;
	logic [CW-1:0] cnt_eff;
	logic [LW-1:0] lim;
	logic [31:0]   off;
	logic          in_acc;
	logic          div_start;
	logic [31:0]   div_dividend;
	fba_pkg::div_res_t div_res;
	logic [32:0]   need;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [1:0]    mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [1:0]    mem_rdata;
	logic [CW-1:0] walk_nxt;
	logic          fin_go;

	assign bs_eff  = (bs_q == 17'd0) ? 17'd1 : ((bs_q > 17'h10000) ? 17'h10000 : bs_q);
	assign cnt_eff = (32'(bc_q) > 32'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(bc_q);
	assign lim     = LW'(bs_eff) * LW'(cnt_eff);
	assign off     = address - base_q;
	assign in_acc  = in_valid && !in_stall;
	assign in_stall = state_q != S_IDLE;
	assign need    = {1'b0, div_res.quot} + 33'(div_res.rem != 17'd0);
	assign walk_nxt = idx_q + CW'(1);
	assign fin_go  = !out_valid_q || !out_stall;

	assign div_start    = in_acc && ((cmd == fba_pkg::CMD_ALLOC && request_size != 32'd0) ||
		(cmd == fba_pkg::CMD_FREE && address >= base_q && 64'(off) < 64'(lim)));
	assign div_dividend = (cmd == fba_pkg::CMD_ALLOC) ? request_size : off;

	fba_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_dividend), .divisor(bs_eff), .res(div_res)
	);

	fba_map #(.MAX_BLOCKS(MAX_BLOCKS)) u_map (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
	);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_wdata = fba_pkg::ENT_FREE;
		mem_re    = 1'b0;
		mem_raddr = idx_q[AW-1:0];
		case (state_q)
			S_CLR: mem_we = 1'b1;
			S_SCAN: mem_re = idx_q < cnt_eff;
			S_MARK: begin
				mem_we    = 1'b1;
				mem_waddr = wr_q;
				mem_wdata = (wr_q == start_q) ? fba_pkg::ENT_START : fba_pkg::ENT_USED;
			end
			S_FRD: begin
				mem_re    = 1'b1;
				mem_raddr = start_q;
			end
			S_FCK: begin
				mem_we    = mem_rdata == fba_pkg::ENT_START;
				mem_waddr = start_q;
				mem_re    = mem_we && (CW'(start_q) + CW'(1) < cnt_eff);
				mem_raddr = AW'(CW'(start_q) + CW'(1));
			end
			S_FWALK: begin
				mem_we    = mem_rdata == fba_pkg::ENT_USED;
				mem_re    = mem_we && (walk_nxt < cnt_eff);
				mem_raddr = walk_nxt[AW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q   <= 17'd16;
			bc_q   <= 11'd1024;
			base_q <= 32'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				fba_pkg::REG_BLOCK_SIZE:  bs_q   <= cfg_data[16:0];
				fba_pkg::REG_BLOCK_COUNT: bc_q   <= cfg_data[10:0];
				fba_pkg::REG_ARENA_BASE:  base_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			idx_q       <= '0;
			clr_res_q   <= 1'b0;
			rv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && fin_go)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						cmd_q      <= cmd;
						res_addr_q <= 32'd0;
						case (cmd)
							fba_pkg::CMD_ALLOC: begin
								if (request_size == 32'd0) begin
									res_st_q <= fba_pkg::ST_ZERO;
									state_q  <= S_FIN;
								end else begin
									res_st_q <= fba_pkg::ST_OK;
									state_q  <= S_DIV;
								end
							end
							fba_pkg::CMD_FREE: begin
								if (div_start) begin
									res_st_q <= fba_pkg::ST_OK;
									state_q  <= S_DIV;
								end else begin
									res_st_q <= fba_pkg::ST_BAD_ADDR;
									state_q  <= S_FIN;
								end
							end
							fba_pkg::CMD_CLEAR: begin
								res_st_q  <= fba_pkg::ST_OK;
								idx_q     <= '0;
								clr_res_q <= 1'b1;
								state_q   <= S_CLR;
							end
							default: begin
								res_st_q <= fba_pkg::ST_OK;
								state_q  <= S_FIN;
							end
						endcase
					end
				end
				S_CLR: begin
					idx_q <= idx_q + CW'(1);
					if (idx_q == CW'(MAX_BLOCKS - 1))
						state_q <= clr_res_q ? S_FIN : S_IDLE;
				end
				S_DIV: begin
					if (div_res.done) begin
						if (cmd_q == fba_pkg::CMD_ALLOC) begin
							if (need > 33'(cnt_eff)) begin
								res_st_q <= fba_pkg::ST_NO_RUN;
								state_q  <= S_FIN;
							end else begin
								need_q  <= CW'(need);
								idx_q   <= '0;
								run_q   <= '0;
								rv_s1   <= 1'b0;
								state_q <= S_SCAN;
							end
						end else if (div_res.rem != 17'd0) begin
							res_st_q <= fba_pkg::ST_BAD_ADDR;
							state_q  <= S_FIN;
						end else begin
							start_q <= AW'(div_res.quot);
							state_q <= S_FRD;
						end
					end
				end
				S_SCAN: begin
					idx_q  <= idx_q + CW'(1);
					rv_s1  <= mem_re;
					pos_s1 <= idx_q;
					if (rv_s1) begin
						if (mem_rdata == fba_pkg::ENT_FREE && run_q + CW'(1) == need_q) begin
							start_q <= AW'(pos_s1 - run_q);
							wr_q    <= AW'(pos_s1 - run_q);
							left_q  <= need_q;
							state_q <= S_MARK;
						end else begin
							run_q <= (mem_rdata == fba_pkg::ENT_FREE) ? run_q + CW'(1) : '0;
							if (pos_s1 == cnt_eff - CW'(1)) begin
								res_st_q <= fba_pkg::ST_NO_RUN;
								state_q  <= S_FIN;
							end
						end
					end
				end
				S_MARK: begin
					wr_q   <= wr_q + AW'(1);
					left_q <= left_q - CW'(1);
					prod_q <= PW'(bs_eff) * PW'(start_q);
					if (left_q == CW'(1))
						state_q <= S_ADDR;
				end
				S_ADDR: begin
					res_addr_q <= base_q + 32'(prod_q);
					state_q    <= S_FIN;
				end
				S_FRD: state_q <= S_FCK;
				S_FCK: begin
					if (mem_rdata != fba_pkg::ENT_START) begin
						res_st_q <= fba_pkg::ST_NOT_START;
						state_q  <= S_FIN;
					end else begin
						idx_q   <= CW'(start_q) + CW'(1);
						state_q <= mem_re ? S_FWALK : S_FIN;
					end
				end
				S_FWALK: begin
					idx_q <= walk_nxt;
					if (!mem_re)
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_go) begin
						clr_res_q <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && fin_go) begin
			status_q <= res_st_q;
			addr_q   <= res_addr_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign block_address = addr_q;

	`FBA_ASSERT_IMPL(a_scan_no_write, state_q == S_SCAN, !mem_we, "map written during scan")
	`FBA_ASSERT_IMPL(a_mark_writes, state_q == S_MARK, mem_we && CW'(wr_q) < cnt_eff, "bad mark write")
	`FBA_ASSERT_IMPL(a_fail_zero_addr, out_valid && status != fba_pkg::ST_OK, block_address == 32'd0, "nonzero address on failure")
endmodule
